>>> rtl/irfi_pkg.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: shared package
// Constants, register indexes, state encoding and the structs shared by the
// frame store controller and its coordinate mapper.
// ----------------------------------------------------------------------------
package irfi_pkg;

  localparam int unsigned MaxDim            = 256;
  localparam int unsigned BytesPerPixelMax  = 3;
  localparam int unsigned DimW              = 9;
  localparam int unsigned CoordW            = 8;
  localparam int unsigned ChanW             = 2;
  localparam int unsigned ByteW             = 8;
  localparam int unsigned TurnW             = 2;
  localparam int unsigned StoreDepth        = MaxDim * MaxDim * BytesPerPixelMax;
  localparam int unsigned StoreAddrW        = $clog2(StoreDepth);
  localparam int unsigned CfgIndexW         = 3;
  localparam int unsigned CfgDataW          = 9;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } item_kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_IMAGE_WIDTH       = 3'd0,
    CFG_IMAGE_HEIGHT      = 3'd1,
    CFG_COLOR_MODE        = 3'd2,
    CFG_MAX_LEVEL         = 3'd3,
    CFG_QUARTER_TURNS     = 3'd4,
    CFG_MIRROR_HORIZONTAL = 3'd5,
    CFG_MIRROR_VERTICAL   = 3'd6,
    CFG_INVERT_ENABLE     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_MAP    = 2'd1,
    ST_ACCESS = 2'd2,
    ST_DATA   = 2'd3
  } state_e;

  typedef struct packed {
    logic [DimW-1:0]  image_width;
    logic [DimW-1:0]  image_height;
    logic             color_mode;
    logic [ByteW-1:0] max_level;
    logic [TurnW-1:0] quarter_turns;
    logic             mirror_horizontal;
    logic             mirror_vertical;
    logic             invert_enable;
  } cfg_t;

  typedef struct packed {
    item_kind_e        kind;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] column;
    logic [ChanW-1:0]  channel;
    logic [ByteW-1:0]  pixel_byte;
  } item_t;

  typedef struct packed {
    logic [StoreAddrW-1:0] addr;
    logic                  src_oor;
    logic                  dst_oor;
  } map_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(MaxDim)) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

endpackage

>>> rtl/irfi_in_if.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: item channel
// Valid/ready channel that carries write and read items into the unit.
// ----------------------------------------------------------------------------
interface irfi_in_if;

  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [irfi_pkg::CoordW-1:0]    row;
  logic [irfi_pkg::CoordW-1:0]    column;
  logic [irfi_pkg::ChanW-1:0]     channel;
  logic [irfi_pkg::ByteW-1:0]     pixel_byte;

  modport source (
    output valid, kind, row, column, channel, pixel_byte,
    input  ready
  );

  modport sink (
    input  valid, kind, row, column, channel, pixel_byte,
    output ready
  );

endinterface

>>> rtl/irfi_out_if.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: result channel
// Valid/ready channel that carries read results out of the unit.
// ----------------------------------------------------------------------------
interface irfi_out_if;

  logic                       valid;
  logic                       ready;
  logic [irfi_pkg::ByteW-1:0] read_byte;
  logic                       out_of_range;

  modport source (
    output valid, read_byte, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, read_byte, out_of_range,
    output ready
  );

endinterface

>>> rtl/irfi_ram.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: generic single-port RAM
// One access per cycle, write or read; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module irfi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/irfi_map.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: coordinate mapper
// Checks an item against the source or output frame, undoes the mirrors and
// the quarter turns of a read, and forms the frame store address.
// ----------------------------------------------------------------------------
module irfi_map (
  input  irfi_pkg::item_t item_i,
  input  irfi_pkg::cfg_t  cfg_i,
  output irfi_pkg::map_t  map_o
);

  logic [irfi_pkg::DimW-1:0]       w, h, ow, oh;
  logic [irfi_pkg::DimW-1:0]       row_x, col_x;
  logic [irfi_pkg::DimW-1:0]       r1, c1;
  logic [irfi_pkg::DimW-1:0]       sr, sc;
  logic [irfi_pkg::CoordW-1:0]     src_row, src_col;
  logic                            ch_ok;
  logic [irfi_pkg::StoreAddrW-1:0] pix;

  always_comb begin
    w     = irfi_pkg::clamp_dim(cfg_i.image_width);
    h     = irfi_pkg::clamp_dim(cfg_i.image_height);
    ow    = cfg_i.quarter_turns[0] ? h : w;
    oh    = cfg_i.quarter_turns[0] ? w : h;
    row_x = {1'b0, item_i.row};
    col_x = {1'b0, item_i.column};
    ch_ok = cfg_i.color_mode ? (item_i.channel < irfi_pkg::ChanW'(irfi_pkg::BytesPerPixelMax))
                             : (item_i.channel == '0);

    map_o.src_oor = (row_x >= h) || (col_x >= w) || !ch_ok;
    map_o.dst_oor = (row_x >= oh) || (col_x >= ow) || !ch_ok;

    r1 = cfg_i.mirror_vertical   ? (oh - irfi_pkg::DimW'(1) - row_x) : row_x;
    c1 = cfg_i.mirror_horizontal ? (ow - irfi_pkg::DimW'(1) - col_x) : col_x;

    case (cfg_i.quarter_turns)
      2'd1: begin
        sr = h - irfi_pkg::DimW'(1) - c1;
        sc = r1;
      end
      2'd2: begin
        sr = h - irfi_pkg::DimW'(1) - r1;
        sc = w - irfi_pkg::DimW'(1) - c1;
      end
      2'd3: begin
        sr = c1;
        sc = w - irfi_pkg::DimW'(1) - r1;
      end
      default: begin
        sr = r1;
        sc = c1;
      end
    endcase

    if (item_i.kind == irfi_pkg::KIND_WRITE) begin
      src_row = item_i.row;
      src_col = item_i.column;
    end else begin
      src_row = sr[irfi_pkg::CoordW-1:0];
      src_col = sc[irfi_pkg::CoordW-1:0];
    end

    pix = irfi_pkg::StoreAddrW'(src_row) * irfi_pkg::StoreAddrW'(irfi_pkg::MaxDim)
        + irfi_pkg::StoreAddrW'(src_col);
    map_o.addr = pix * irfi_pkg::StoreAddrW'(irfi_pkg::BytesPerPixelMax)
               + irfi_pkg::StoreAddrW'(item_i.channel);
  end

endmodule

>>> rtl/image_rotate_flip_invert_unit.sv
// ----------------------------------------------------------------------------
// Image rotate, flip and invert unit: top level
// Frame store of up to 256 x 256 pixels, gray or RGB, with a read path that
// rotates by quarter turns, mirrors and optionally inverts the stored image.
//
// Items enter on src_i. A write stores pixel_byte at a source row, column and
// channel and produces no transfer on res_o; a write outside the source frame
// is dropped. A read names a byte of the transformed frame and produces one
// transfer on res_o with read_byte and out_of_range.
// One item is handled at a time. A write passes the map and access states, a
// read also the data state, in which its result enters the output register.
// A read result waits in the output register while the receiver stalls, and
// the next item is already accepted meanwhile; a further read then waits at
// its last step until the register is free. Configuration is written through
// cfg_we_i, cfg_index_i and cfg_data_i while the unit is idle; the user must
// keep to this, as the block does not enforce it. Reset restores the register
// defaults and empties the output register; the frame store contents are
// undefined until written.
// ----------------------------------------------------------------------------
module image_rotate_flip_invert_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irfi_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [irfi_pkg::CfgDataW-1:0]  cfg_data_i,
  irfi_in_if.sink                        src_i,
  irfi_out_if.source                     res_o
);

  irfi_pkg::cfg_t   cfg_q;
  irfi_pkg::item_t  item_q, item_in;
  irfi_pkg::map_t   map_d, map_q;
  irfi_pkg::state_e state_q, state_d;

  logic                       in_ready;
  logic                       ram_we, ram_re;
  logic                       out_load;
  logic [irfi_pkg::ByteW-1:0] ram_rdata;
  logic [irfi_pkg::ByteW-1:0] inv_byte, res_byte;
  logic                       out_valid_q;
  logic [irfi_pkg::ByteW-1:0] read_byte_q;
  logic                       oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width       <= irfi_pkg::DimW'(irfi_pkg::MaxDim);
      cfg_q.image_height      <= irfi_pkg::DimW'(irfi_pkg::MaxDim);
      cfg_q.color_mode        <= 1'b0;
      cfg_q.max_level         <= '1;
      cfg_q.quarter_turns     <= '0;
      cfg_q.mirror_horizontal <= 1'b0;
      cfg_q.mirror_vertical   <= 1'b0;
      cfg_q.invert_enable     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (irfi_pkg::cfg_reg_e'(cfg_index_i))
        irfi_pkg::CFG_IMAGE_WIDTH:       cfg_q.image_width <= cfg_data_i;
        irfi_pkg::CFG_IMAGE_HEIGHT:      cfg_q.image_height <= cfg_data_i;
        irfi_pkg::CFG_COLOR_MODE:        cfg_q.color_mode <= cfg_data_i[0];
        irfi_pkg::CFG_MAX_LEVEL:         cfg_q.max_level <= cfg_data_i[irfi_pkg::ByteW-1:0];
        irfi_pkg::CFG_QUARTER_TURNS:     cfg_q.quarter_turns <= cfg_data_i[irfi_pkg::TurnW-1:0];
        irfi_pkg::CFG_MIRROR_HORIZONTAL: cfg_q.mirror_horizontal <= cfg_data_i[0];
        irfi_pkg::CFG_MIRROR_VERTICAL:   cfg_q.mirror_vertical <= cfg_data_i[0];
        irfi_pkg::CFG_INVERT_ENABLE:     cfg_q.invert_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign item_in.kind       = irfi_pkg::item_kind_e'(src_i.kind);
  assign item_in.row        = src_i.row;
  assign item_in.column     = src_i.column;
  assign item_in.channel    = src_i.channel;
  assign item_in.pixel_byte = src_i.pixel_byte;

  always_ff @(posedge clk_i) begin
    if (src_i.valid && in_ready) begin
      item_q <= item_in;
    end
    if (state_q == irfi_pkg::ST_MAP) begin
      map_q <= map_d;
    end
  end

  irfi_map u_map (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .map_o  (map_d)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      irfi_pkg::ST_IDLE: begin
        if (src_i.valid) begin
          state_d = irfi_pkg::ST_MAP;
        end
      end
      irfi_pkg::ST_MAP: begin
        state_d = irfi_pkg::ST_ACCESS;
      end
      irfi_pkg::ST_ACCESS: begin
        if (item_q.kind == irfi_pkg::KIND_WRITE) begin
          state_d = irfi_pkg::ST_IDLE;
        end else begin
          state_d = irfi_pkg::ST_DATA;
        end
      end
      irfi_pkg::ST_DATA: begin
        if (!out_valid_q || res_o.ready) begin
          state_d = irfi_pkg::ST_IDLE;
        end
      end
      default: state_d = irfi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      irfi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      irfi_pkg::ST_MAP: ;
      irfi_pkg::ST_ACCESS: begin
        ram_we = (item_q.kind == irfi_pkg::KIND_WRITE) && !map_q.src_oor;
        ram_re = (item_q.kind == irfi_pkg::KIND_READ) && !map_q.dst_oor;
      end
      irfi_pkg::ST_DATA: begin
        out_load = !out_valid_q || res_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irfi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  irfi_ram #(
    .Width (irfi_pkg::ByteW),
    .Depth (irfi_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (map_q.addr),
    .wdata_i (item_q.pixel_byte),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    inv_byte = (ram_rdata > cfg_q.max_level) ? '0 : (cfg_q.max_level - ram_rdata);
    if (map_q.dst_oor) begin
      res_byte = '0;
    end else if (cfg_q.invert_enable) begin
      res_byte = inv_byte;
    end else begin
      res_byte = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_byte_q <= res_byte;
      oor_q       <= map_q.dst_oor;
    end
  end

  assign src_i.ready        = in_ready;
  assign res_o.valid        = out_valid_q;
  assign res_o.read_byte    = read_byte_q;
  assign res_o.out_of_range = oor_q;

endmodule
